// ===== sv/gri_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gri_pkg: shared types and constants for the gyro rate integrator
// Field widths, command and phase codes, divider request/response structs.
// ----------------------------------------------------------------------------
package gri_pkg;

  localparam int SAMPLE_W  = 8;
  localparam int TOTAL_W   = 16;
  localparam int DIVISOR_W = 15;
  localparam int MATCH_W   = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [DIVISOR_W-1:0] DIVISOR_RST = DIVISOR_W'(145);
  localparam logic [MATCH_W-1:0]   MATCHES_RST = MATCH_W'(5);

  localparam logic [CFG_IDX_W-1:0] REG_DIVISOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MATCHES = 1'b1;

  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_START  = 2'd1,
    MODE_STOP   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CAL  = 2'd1,
    PH_ACC  = 2'd2
  } phase_t;

  typedef struct packed {
    logic                        start;
    logic signed [TOTAL_W-1:0]   dividend;
    logic        [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [TOTAL_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== sv/gri_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gri_div: iterative signed by unsigned divider
// Radix-2 restoring divide, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module gri_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire gri_pkg::div_req_t req,
  output gri_pkg::div_rsp_t      rsp
);

  localparam int TW = gri_pkg::TOTAL_W;
  localparam int DW = gri_pkg::DIVISOR_W;
  localparam int CW = $clog2(TW);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          neg_r;
  logic [TW-1:0] quo_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] dvs_r;

  logic [DW:0]   trial;
  logic [DW+1:0] diff;
  logic          fits;
  logic [TW-1:0] mag;

  always_comb begin
    trial = {rem_r, quo_r[TW-1]};
    diff  = {1'b0, trial} - {2'b00, dvs_r};
    fits  = ~diff[DW+1];
    mag   = req.dividend[TW-1] ? TW'(-req.dividend) : TW'(req.dividend);
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(TW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg_r <= req.dividend[TW-1];
      quo_r <= mag;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DW-1:0] : trial[DW-1:0];
      quo_r <= {quo_r[TW-2:0], fits};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? $signed(-quo_r) : $signed(quo_r);

endmodule
`default_nettype wire

// ===== sv/gyro_rate_integrator_autozero.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gyro_rate_integrator_autozero: gyro zero calibration and rate integration
// Each input transfer starts the 16-step iterative divider, and the input
// stalls until that item's result is taken into the output register.
// A finished result waits in the output register while the next item runs.
// Reset (synchronous, rst_n low): phase idle, count, offset and total zero,
// divisor 145, required matches 5, no result pending.
// ----------------------------------------------------------------------------
module gyro_rate_integrator_autozero (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [gri_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [gri_pkg::DIVISOR_W-1:0]        cfg_wdata,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [1:0]                           in_mode,
  input  wire logic [gri_pkg::SAMPLE_W-1:0]         in_rate_sample,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [1:0]                                out_phase,
  output logic [gri_pkg::SAMPLE_W-1:0]              out_zero_offset,
  output logic signed [gri_pkg::TOTAL_W-1:0]        out_raw_total,
  output logic signed [gri_pkg::TOTAL_W-1:0]        out_degrees
);

  localparam int SW = gri_pkg::SAMPLE_W;
  localparam int TW = gri_pkg::TOTAL_W;
  localparam int DW = gri_pkg::DIVISOR_W;
  localparam int MW = gri_pkg::MATCH_W;

  typedef enum logic [1:0] {
    ST_READY,
    ST_DIV,
    ST_PUSH
  } seq_t;

  seq_t              st_r, st_nxt;
  logic [DW-1:0]     divisor_r, divisor_nxt;
  logic [MW-1:0]     req_match_r, req_match_nxt;
  gri_pkg::phase_t   phase_r, phase_nxt;
  logic [MW-1:0]     match_r, match_nxt;
  logic [SW-1:0]     offset_r, offset_nxt;
  logic [TW-1:0]     total_r, total_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              div_start_r, div_start_nxt;
  logic signed [TW-1:0] quot_r;
  logic [1:0]        out_phase_r;
  logic [SW-1:0]     out_offset_r;
  logic [TW-1:0]     out_total_r;
  logic signed [TW-1:0] out_deg_r;

  logic              in_xfer;
  logic              push;
  logic [MW-1:0]     match_inc;
  gri_pkg::div_req_t div_req;
  gri_pkg::div_rsp_t div_rsp;

  gri_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_stall  = (st_r != ST_READY);
  assign in_xfer   = in_valid && !in_stall;
  assign push      = (st_r == ST_PUSH) && (!out_valid_r || !out_stall);
  assign match_inc = (in_rate_sample == offset_r) ? match_r + MW'(1) : '0;

  always_comb begin
    div_req.start    = div_start_r;
    div_req.dividend = $signed(total_r);
    div_req.divisor  = (divisor_r == '0) ? DW'(1) : divisor_r;
  end

  always_comb begin
    divisor_nxt   = divisor_r;
    req_match_nxt = req_match_r;
    if (cfg_we) begin
      unique case (cfg_index)
        gri_pkg::REG_DIVISOR: divisor_nxt   = cfg_wdata;
        gri_pkg::REG_MATCHES: req_match_nxt = cfg_wdata[MW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    match_nxt  = match_r;
    offset_nxt = offset_r;
    total_nxt  = total_r;
    if (in_xfer) begin
      case (gri_pkg::mode_t'(in_mode))
        gri_pkg::MODE_SAMPLE: begin
          if (phase_r == gri_pkg::PH_CAL) begin
            offset_nxt = in_rate_sample;
            match_nxt  = match_inc;
            if (match_inc == req_match_r) begin
              phase_nxt = gri_pkg::PH_ACC;
              match_nxt = '0;
            end
          end else if (phase_r == gri_pkg::PH_ACC) begin
            total_nxt = total_r + TW'(in_rate_sample) - TW'(offset_r);
          end
        end
        gri_pkg::MODE_START: begin
          if (phase_r == gri_pkg::PH_IDLE) phase_nxt = gri_pkg::PH_CAL;
        end
        gri_pkg::MODE_STOP:  phase_nxt = gri_pkg::PH_IDLE;
        gri_pkg::MODE_CLEAR: total_nxt = '0;
        default: ;
      endcase
    end
  end

  always_comb begin
    st_nxt        = st_r;
    div_start_nxt = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (st_r)
      ST_READY: begin
        if (in_xfer) begin
          st_nxt        = ST_DIV;
          div_start_nxt = 1'b1;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) st_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (push) begin
          st_nxt        = ST_READY;
          out_valid_nxt = 1'b1;
        end
      end
      default: st_nxt = ST_READY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_READY;
      divisor_r   <= gri_pkg::DIVISOR_RST;
      req_match_r <= gri_pkg::MATCHES_RST;
      phase_r     <= gri_pkg::PH_IDLE;
      match_r     <= '0;
      offset_r    <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      divisor_r   <= divisor_nxt;
      req_match_r <= req_match_nxt;
      phase_r     <= phase_nxt;
      match_r     <= match_nxt;
      offset_r    <= offset_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      div_start_r <= div_start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (div_rsp.done) quot_r <= div_rsp.quotient;
    if (push) begin
      out_phase_r  <= phase_r;
      out_offset_r <= offset_r;
      out_total_r  <= total_r;
      out_deg_r    <= quot_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_phase       = out_phase_r;
  assign out_zero_offset = out_offset_r;
  assign out_raw_total   = $signed(out_total_r);
  assign out_degrees     = out_deg_r;

`ifndef SYNTH
  a_start_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> div_start_r)
    else $error("divider not started after input transfer");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> st_r == ST_DIV)
    else $error("divider finished outside divide state");

  a_acc_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == gri_pkg::PH_ACC |-> match_r == '0)
    else $error("match count not clear while accumulating");

  a_push_phase: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_phase != 2'd3)
    else $error("invalid phase reported");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_gyro_rate_integrator_autozero.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gyro_rate_integrator_autozero: self-checking bench for the integrator
// Drives commands and rate samples through the valid/stall input channel and
// predicts each reading (phase, offset, raw total, degrees) with its own
// calibration and accumulation model. Readings are checked in order. The run
// walks through several divisor and match-count settings, including the
// extremes, and several idling patterns. It also holds the output off long
// enough for the block to stall its input.
// ----------------------------------------------------------------------------
module tb_gyro_rate_integrator_autozero;

  localparam int HOLD_CYCLES = 300;
  localparam int MAX_PRINTS  = 30;
  localparam int SW = gri_pkg::SAMPLE_W;
  localparam int TW = gri_pkg::TOTAL_W;
  localparam int DW = gri_pkg::DIVISOR_W;
  localparam int MW = gri_pkg::MATCH_W;
  localparam int IW = gri_pkg::CFG_IDX_W;

  typedef struct packed {
    gri_pkg::mode_t    mode;
    logic [SW-1:0]     sample;
  } gyro_cmd_t;

  typedef struct packed {
    gri_pkg::phase_t           phase;
    logic [SW-1:0]             offset;
    logic signed [TW-1:0]      total;
    logic signed [TW-1:0]      deg;
  } reading_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [IW-1:0]         cfg_index = '0;
  logic [DW-1:0]         cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_mode = gri_pkg::MODE_SAMPLE;
  logic [SW-1:0]         in_rate_sample = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            out_phase;
  logic [SW-1:0]         out_zero_offset;
  logic signed [TW-1:0]  out_raw_total;
  logic signed [TW-1:0]  out_degrees;

  gyro_rate_integrator_autozero i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_rate_sample  (in_rate_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_phase       (out_phase),
    .out_zero_offset (out_zero_offset),
    .out_raw_total   (out_raw_total),
    .out_degrees     (out_degrees)
  );

  // predictor state and configuration
  gri_pkg::phase_t           m_phase   = gri_pkg::PH_IDLE;
  logic [MW-1:0]             m_count   = '0;
  logic [SW-1:0]             m_offset  = '0;
  logic signed [TW-1:0]      m_total   = '0;
  logic [DW-1:0]             m_divisor = gri_pkg::DIVISOR_RST;
  logic [MW-1:0]             m_matches = gri_pkg::MATCHES_RST;

  gyro_cmd_t pending_items[$];
  reading_t  expected_readings[$];
  gyro_cmd_t next_cmd;
  reading_t  front_reading;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_reqs = 0;
  int holds_begun = 0;
  int hold_left = 0;
  logic in_taken = 1'b0;

  int queued_total = 0;
  int items_taken = 0;
  int readings_checked = 0;
  int mismatch_count = 0;
  int cal_completions = 0;
  int total_wraps = 0;
  int blocked_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    if (mismatch_count < MAX_PRINTS)
      $display("mismatch on %s at reading %0d: got %h, expected %h",
               what, readings_checked, got, want);
    mismatch_count++;
  endtask

  function automatic void integrate_item(gri_pkg::mode_t mode, logic [SW-1:0] s);
    reading_t r;
    int       exact;
    int       q;
    case (mode)
      gri_pkg::MODE_SAMPLE: begin
        if (m_phase == gri_pkg::PH_CAL) begin
          m_count = (s == m_offset) ? m_count + 8'd1 : 8'd0;
          m_offset = s;
          if (m_count == m_matches) begin
            m_phase = gri_pkg::PH_ACC;
            m_count = '0;
            cal_completions++;
          end
        end else if (m_phase == gri_pkg::PH_ACC) begin
          exact = int'(m_total) + int'(s) - int'(m_offset);
          if (exact > 32767 || exact < -32768) total_wraps++;
          m_total = exact[TW-1:0];
        end
      end
      gri_pkg::MODE_START: if (m_phase == gri_pkg::PH_IDLE) m_phase = gri_pkg::PH_CAL;
      gri_pkg::MODE_STOP:  m_phase = gri_pkg::PH_IDLE;
      default:             m_total = '0;
    endcase
    q = int'(m_total) / ((m_divisor == '0) ? 1 : int'(m_divisor));
    r.phase  = m_phase;
    r.offset = m_offset;
    r.total  = m_total;
    r.deg    = q[TW-1:0];
    expected_readings.push_back(r);
  endfunction

  // sender: holds the payload until it is transferred
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_cmd = pending_items.pop_front();
        in_valid       <= 1'b1;
        in_mode        <= next_cmd.mode;
        in_rate_sample <= next_cmd.sample;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall, plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != holds_begun) begin
      out_stall   <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      holds_begun <= holds_begun + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor: predicts on each input transfer, checks each result transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && in_stall) blocked_cycles++;
      if (in_valid && !in_stall) begin
        integrate_item(gri_pkg::mode_t'(in_mode), in_rate_sample);
        items_taken++;
      end
      if (out_valid === 1'b1 && !out_stall) begin
        if (expected_readings.size() == 0) begin
          flag_mismatch("unexpected result", out_raw_total, '0);
        end else begin
          front_reading = expected_readings.pop_front();
          if (out_phase !== front_reading.phase)
            flag_mismatch("phase", out_phase, front_reading.phase);
          if (out_zero_offset !== front_reading.offset)
            flag_mismatch("zero_offset", out_zero_offset, front_reading.offset);
          if (out_raw_total !== front_reading.total)
            flag_mismatch("raw_total", out_raw_total, front_reading.total);
          if (out_degrees !== front_reading.deg)
            flag_mismatch("degrees", out_degrees, front_reading.deg);
        end
        readings_checked++;
      end
    end
  end

  task automatic queue_cmd(input gri_pkg::mode_t m, input logic [SW-1:0] s);
    gyro_cmd_t c;
    c.mode   = m;
    c.sample = s;
    pending_items.push_back(c);
    queued_total++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (items_taken != queued_total || expected_readings.size() != 0);
  endtask

  task automatic write_reg(input logic [IW-1:0] idx,
                           input logic [DW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == gri_pkg::REG_DIVISOR) m_divisor = val;
    else m_matches = val[MW-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic begin_phase(input logic [DW-1:0] div,
                             input logic [DW-1:0] match_goal,
                             input int send_pct, input int stall_pct);
    wait_drained();
    write_reg(gri_pkg::REG_DIVISOR, div);
    write_reg(gri_pkg::REG_MATCHES, match_goal);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  // start, a run of equal samples, accumulation, usually a stop; some noise
  task automatic queue_sessions(input int n);
    int goal, need, run, k, v, w, i;
    bit burst;
    goal = queued_total + n;
    while (queued_total < goal) begin
      if ($urandom_range(99) < 15) begin
        queue_cmd(gri_pkg::mode_t'($urandom_range(3)), SW'($urandom));
      end else begin
        need  = (m_matches == '0) ? 256 : int'(m_matches);
        v     = $urandom_range(255);
        burst = ($urandom_range(9) == 0);
        if (burst) v = $urandom_range(1) ? 255 : 0;
        queue_cmd(gri_pkg::MODE_START, SW'($urandom));
        run = need + 1;
        if ($urandom_range(4) == 0) run = $urandom_range(need);
        for (i = 0; i < run && queued_total < goal; i++)
          queue_cmd(gri_pkg::MODE_SAMPLE, SW'(v));
        k = burst ? 140 + $urandom_range(60) : $urandom_range(3, 30);
        for (i = 0; i < k && queued_total < goal; i++) begin
          if (burst) begin
            w = 255 - v;
          end else begin
            case ($urandom_range(5))
              0: w = 0;
              1: w = 255;
              2: w = v;
              3: w = (v == 255) ? v : v + 1;
              4: w = (v == 0) ? v : v - 1;
              default: w = $urandom_range(255);
            endcase
          end
          if (!burst && $urandom_range(19) == 0)
            queue_cmd(gri_pkg::MODE_CLEAR, SW'($urandom));
          else queue_cmd(gri_pkg::MODE_SAMPLE, SW'(w));
        end
        if (queued_total < goal && $urandom_range(4) != 0)
          queue_cmd(gri_pkg::MODE_STOP, SW'($urandom));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: ignored commands, interrupted and resumed calibration
    queue_cmd(gri_pkg::MODE_SAMPLE, 8'hFF);
    queue_cmd(gri_pkg::MODE_CLEAR,  8'h00);
    queue_cmd(gri_pkg::MODE_START,  8'h00);
    queue_cmd(gri_pkg::MODE_START,  8'hFF);
    repeat (3) queue_cmd(gri_pkg::MODE_SAMPLE, 8'hA5);
    queue_cmd(gri_pkg::MODE_STOP,   8'h5A);
    queue_cmd(gri_pkg::MODE_SAMPLE, 8'h00);
    queue_cmd(gri_pkg::MODE_START,  8'h00);
    repeat (3) queue_cmd(gri_pkg::MODE_SAMPLE, 8'hA5);
    queue_cmd(gri_pkg::MODE_SAMPLE, 8'hFF);
    repeat (3) queue_cmd(gri_pkg::MODE_SAMPLE, 8'h00);
    queue_cmd(gri_pkg::MODE_START,  8'h00);
    queue_cmd(gri_pkg::MODE_CLEAR,  8'hFF);
    queue_cmd(gri_pkg::MODE_SAMPLE, 8'h5A);
    queue_cmd(gri_pkg::MODE_STOP,   8'h00);
    queue_cmd(gri_pkg::MODE_SAMPLE, 8'h33);
    queue_cmd(gri_pkg::MODE_CLEAR,  8'h00);

    begin_phase(15'd1, 15'd1, 0, 0);
    hold_reqs++;
    queue_sessions(420);

    begin_phase(15'h7FFF, 15'h7FFF, 74, 0);
    queue_sessions(400);

    begin_phase(15'd0, 15'h7F00, 0, 74);
    queue_sessions(400);

    begin_phase(DW'($urandom_range(2, 32766)),
                DW'($urandom_range(2, 8)), 26, 26);
    queue_sessions(400);

    wait_drained();
    repeat (40) @(negedge clk);
    $display("run covered %0d transfers in and %0d results, %0d calibrations finished",
             items_taken, readings_checked, cal_completions);
    $display("accumulator wrapped %0d times; input held off for %0d cycles",
             total_wraps, blocked_cycles);
    if (mismatch_count == 0 && expected_readings.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("run timed out with %0d results outstanding", expected_readings.size());
    $display("status: fail");
    $finish;
  end

endmodule
